// ===== rtl/core/gac_pkg.sv =====
package gac_pkg;

  // field widths
  localparam int unsigned SampleW = 12;
  localparam int unsigned LevelW  = 11;
  localparam int unsigned IvalW   = 16;
  localparam int unsigned DebW    = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // register reset values
  localparam logic signed [LevelW-1:0] ThreshRst   = 11'sd600;
  localparam logic [IvalW-1:0]         SampleRst   = 16'd3000;
  localparam logic [IvalW-1:0]         EvalRst     = 16'd1000;
  localparam logic [IvalW-1:0]         ToggleRst   = 16'd500;
  localparam logic [DebW-1:0]          DebounceRst = 8'd10;

  // linear rescale 0..4095 -> -1000..900
  localparam logic [22:0] ScaleMul = 23'd1900;
  localparam logic [12:0] ScaleDiv = 13'd4095;
  localparam logic [11:0] ScaleOff = 12'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_SAMPLE    = 3'd1,
    REG_EVAL      = 3'd2,
    REG_TOGGLE    = 3'd3,
    REG_DEBOUNCE  = 3'd4
  } gac_reg_e;

  // floor(sample * 1900 / 4095) - 1000, no divider:
  // x = a*4096 + b = a*4095 + (a + b), and a + b < 2*4095
  function automatic logic signed [LevelW-1:0] scale_level(input logic [SampleW-1:0] smp);
    logic [22:0] prod;
    logic [10:0] hi;
    logic [12:0] sum;
    logic [10:0] quot;
    logic [11:0] lvl;
    prod = {11'd0, smp} * ScaleMul;
    hi   = prod[22:12];
    sum  = {2'd0, hi} + {1'b0, prod[11:0]};
    quot = hi + {10'd0, (sum >= ScaleDiv)};
    lvl  = {1'b0, quot} - ScaleOff;
    return lvl[LevelW-1:0];
  endfunction

endpackage

// ===== rtl/core/gas_alarm_controller.sv =====
// gas_alarm_controller: millisecond-tick gas alarm with debounced mute
// result: each accepted input beat is registered and shown as its result beat in the next cycle
// throughput: one tick per cycle unless stalled; single output reg drains as next is taken
// reset: async active-low; config back to defaults, time and all alarm state cleared,
//   buzzer toggle phase set, output register empty
module gas_alarm_controller
  import gac_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config write port
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  // tick input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [SampleW-1:0]       sensor_sample_i,
  input  logic                     button_edge_i,
  input  logic                     remote_mute_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [LevelW-1:0] gas_level_o,
  output logic                     level_updated_o,
  output logic                     red_led_o,
  output logic                     green_led_o,
  output logic                     buzzer_drive_o,
  output logic                     alert_pulse_o
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [LevelW-1:0] thresh_q;
  logic [IvalW-1:0]         samp_ival_q;
  logic [IvalW-1:0]         eval_ival_q;
  logic [IvalW-1:0]         tog_ival_q;
  logic [DebW-1:0]          deb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= ThreshRst;
      samp_ival_q <= SampleRst;
      eval_ival_q <= EvalRst;
      tog_ival_q  <= ToggleRst;
      deb_q       <= DebounceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: thresh_q    <= cfg_wdata_i[LevelW-1:0];
        REG_SAMPLE:    samp_ival_q <= cfg_wdata_i[IvalW-1:0];
        REG_EVAL:      eval_ival_q <= cfg_wdata_i[IvalW-1:0];
        REG_TOGGLE:    tog_ival_q  <= cfg_wdata_i[IvalW-1:0];
        REG_DEBOUNCE:  deb_q       <= cfg_wdata_i[DebW-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: take a tick whenever the output register is empty or draining
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------------------
  // per-tick state
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0]         now_q, now_d;
  logic [TimeW-1:0]         press_q, press_d;
  logic [TimeW-1:0]         samp_t_q, samp_t_d;
  logic [TimeW-1:0]         tog_t_q, tog_t_d;
  logic [IvalW-1:0]         cnt_q, cnt_d;
  logic signed [LevelW-1:0] level_q, level_d;
  logic                     muted_q, muted_d;
  logic                     phase_q, phase_d;
  logic                     buzz_q, buzz_d;
  logic                     red_q, red_d;
  logic                     green_q, green_d;
  logic                     updated, alert;

  // elapsed-time checks, all modulo 2^32
  logic [TimeW-1:0] press_age, samp_age, tog_age;
  logic             press_ok, samp_ok, tog_ok;
  logic [IvalW:0]   cnt_next;
  logic             eval_now;
  logic             mute_evt;
  logic signed [LevelW-1:0] scaled;

  assign press_age = now_q - press_q;
  assign samp_age  = now_q - samp_t_q;
  assign tog_age   = now_q - tog_t_q;
  assign press_ok  = button_edge_i && (press_age >= {{(TimeW-DebW){1'b0}}, deb_q});
  assign samp_ok   = samp_age >= {{(TimeW-IvalW){1'b0}}, samp_ival_q};
  assign tog_ok    = tog_age >= {{(TimeW-IvalW){1'b0}}, tog_ival_q};
  assign cnt_next  = {1'b0, cnt_q} + {{IvalW{1'b0}}, 1'b1};
  assign eval_now  = cnt_next >= {1'b0, eval_ival_q};
  assign mute_evt  = press_ok | remote_mute_i;
  assign scaled    = scale_level(sensor_sample_i);

  always_comb begin
    now_d    = now_q + {{(TimeW-1){1'b0}}, 1'b1};
    press_d  = press_q;
    samp_t_d = samp_t_q;
    tog_t_d  = tog_t_q;
    cnt_d    = cnt_next[IvalW-1:0];
    level_d  = level_q;
    muted_d  = muted_q;
    phase_d  = phase_q;
    buzz_d   = buzz_q;
    red_d    = red_q;
    green_d  = green_q;
    updated  = 1'b0;
    alert    = 1'b0;

    // mute events come first within a tick
    if (press_ok) begin
      press_d = now_q;
    end
    if (mute_evt) begin
      buzz_d  = 1'b0;
      muted_d = 1'b1;
    end

    if (eval_now) begin
      cnt_d = '0;
      if (samp_ok) begin
        samp_t_d = now_q;
        level_d  = scaled;
        updated  = 1'b1;
      end
      if (level_d > thresh_q) begin
        green_d = 1'b1;
        red_d   = 1'b1;
        alert   = 1'b1;
        if (!muted_d && tog_ok) begin
          tog_t_d = now_q;
          phase_d = ~phase_q;
          buzz_d  = ~phase_q;
        end
      end else begin
        green_d = 1'b1;
        red_d   = 1'b0;
        buzz_d  = 1'b0;
        muted_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q    <= '0;
      press_q  <= '0;
      samp_t_q <= '0;
      tog_t_q  <= '0;
      cnt_q    <= '0;
      level_q  <= '0;
      muted_q  <= 1'b0;
      phase_q  <= 1'b1;
      buzz_q   <= 1'b0;
      red_q    <= 1'b0;
      green_q  <= 1'b0;
    end else if (accept) begin
      now_q    <= now_d;
      press_q  <= press_d;
      samp_t_q <= samp_t_d;
      tog_t_q  <= tog_t_d;
      cnt_q    <= cnt_d;
      level_q  <= level_d;
      muted_q  <= muted_d;
      phase_q  <= phase_d;
      buzz_q   <= buzz_d;
      red_q    <= red_d;
      green_q  <= green_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register: one beat per tick
  // ---------------------------------------------------------------------------
  logic signed [LevelW-1:0] gas_level_q;
  logic                     upd_q, red_out_q, green_out_q, buzz_out_q, alert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      gas_level_q <= level_d;
      upd_q       <= updated;
      red_out_q   <= red_d;
      green_out_q <= green_d;
      buzz_out_q  <= buzz_d;
      alert_q     <= alert;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gas_level_o     = gas_level_q;
  assign level_updated_o = upd_q;
  assign red_led_o       = red_out_q;
  assign green_led_o     = green_out_q;
  assign buzzer_drive_o  = buzz_out_q;
  assign alert_pulse_o   = alert_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // red is never lit without green
  a_red_has_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!red_led_o || green_led_o))
    else $error("red lit without green");

  // an alert beat always shows the red indicator
  a_alert_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alert_pulse_o) |-> red_led_o)
    else $error("alert without red");

  // the buzzer only sounds while the alarm is raised
  a_buzz_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && buzzer_drive_o) |-> red_led_o)
    else $error("buzzer on without alarm");

  // a stalled beat that is not taken stays in the output register
  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output beat lost under stall");

endmodule
